[rtl/gdda_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian date day arithmetic block.
package gdda_pkg;

  // Only the low DAY_COUNT_BITS of the 16-bit day count take part in arithmetic.
  localparam int DAY_COUNT_BITS = 16;
  localparam int CNT_W          = (DAY_COUNT_BITS < 16) ? DAY_COUNT_BITS : 16;

  // Accumulator width: covers day numbers up to the last day of year 9999 plus
  // the largest day count, and down to minus the largest day count.
  localparam int ACC_W = 24;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t CYCLE_DAYS   = acc_t'(146097);  // days in 400 years
  localparam acc_t CENT_LEAP    = acc_t'(36525);   // century that starts on a leap year
  localparam acc_t CENT_PLAIN   = acc_t'(36524);
  localparam acc_t BLOCK_LEAP   = acc_t'(1461);    // four years that start on a leap year
  localparam acc_t BLOCK_PLAIN  = acc_t'(1460);
  localparam acc_t YEAR_LEAP    = acc_t'(366);
  localparam acc_t YEAR_PLAIN   = acc_t'(365);
  localparam acc_t SERIAL_MAX   = acc_t'(3652424); // 31 December 9999

  localparam logic [13:0] YEAR_MAX = 14'd9999;

  typedef enum logic [1:0] {
    ACT_ADD  = 2'd0,
    ACT_SUB  = 2'd1,
    ACT_DIFF = 2'd2,
    ACT_CMP  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ORD_EQUAL     = 2'd0,
    ORD_A_LATER   = 2'd1,
    ORD_A_EARLIER = 2'd2
  } order_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  day_a;
    logic [3:0]  month_a;
    logic [13:0] year_a;
    logic [4:0]  day_b;
    logic [3:0]  month_b;
    logic [13:0] year_b;
    logic [15:0] day_count;
  } req_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] diff;
    order_t      order;
    logic        err;
  } res_t;

  // Length of month m (1..12) in a year whose leap status is given.
  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/gregorian_date_day_arithmetic.sv]
// Gregorian date day arithmetic top level: command port, sequencer and result register.
// The time from an accepted transaction to its result strobe grows with the years and
// months stepped through on the one shared adder, by 400-, 100-, 4- and 1-year blocks and
// then month by month; one transaction is in flight at a time.
// rst_n is synchronous and active low; it returns the sequencer to idle and clears the strobe.
// Each result is marked on the out_ ports by out_valid, which is high for exactly one cycle.
module gregorian_date_day_arithmetic (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [4:0]  in_day_a,
  input  logic [3:0]  in_month_a,
  input  logic [13:0] in_year_a,
  input  logic [4:0]  in_day_b,
  input  logic [3:0]  in_month_b,
  input  logic [13:0] in_year_b,
  input  logic [15:0] in_day_count,
  output logic        out_valid,
  output logic [4:0]  out_res_day,
  output logic [3:0]  out_res_month,
  output logic [13:0] out_res_year,
  output logic [21:0] out_day_difference,
  output logic [1:0]  out_order,
  output logic        out_range_error
);
  import gdda_pkg::*;

  req_t        req;
  res_t        seq_res;
  logic        seq_busy;
  logic        seq_done;

  logic        out_valid_r;
  logic [4:0]  res_day_r;
  logic [3:0]  res_month_r;
  logic [13:0] res_year_r;
  logic [21:0] day_difference_r;
  logic [1:0]  order_r;
  logic        range_error_r;

  // Gather the command fields into one request word for the sequencer.
  assign req.action    = action_t'(in_action);
  assign req.day_a     = in_day_a;
  assign req.month_a   = in_month_a;
  assign req.year_a    = in_year_a;
  assign req.day_b     = in_day_b;
  assign req.month_b   = in_month_b;
  assign req.year_b    = in_year_b;
  assign req.day_count = in_day_count;

  // The sequencer turns each date into a day number counted from 1 January of
  // year 0, then either adds or subtracts the day count and walks the sum back
  // into a calendar date, or subtracts the two day numbers for the difference
  // and compare actions.  It only looks at start while it is idle, so the
  // transaction is taken exactly when start is high and busy is low.
  gdda_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .req   (req),
    .busy  (seq_busy),
    .done  (seq_done),
    .res   (seq_res)
  );

  // The result register loads the result fields once per transaction and holds them until the next result.
  // Fields that the action does not produce are forced to zero here, so the
  // sequencer can leave stale values in them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= seq_done;
      if (seq_done) begin
        case (seq_res.action) inside
          ACT_ADD, ACT_SUB: begin
            res_day_r        <= seq_res.day;
            res_month_r      <= seq_res.month;
            res_year_r       <= seq_res.year;
            range_error_r    <= seq_res.err;
            day_difference_r <= '0;
            order_r          <= ORD_EQUAL;
          end
          ACT_DIFF: begin
            res_day_r        <= '0;
            res_month_r      <= '0;
            res_year_r       <= '0;
            range_error_r    <= 1'b0;
            day_difference_r <= seq_res.diff;
            order_r          <= ORD_EQUAL;
          end
          default: begin
            res_day_r        <= '0;
            res_month_r      <= '0;
            res_year_r       <= '0;
            range_error_r    <= 1'b0;
            day_difference_r <= '0;
            order_r          <= seq_res.order;
          end
        endcase
      end
    end
  end

  assign busy               = seq_busy;
  assign out_valid          = out_valid_r;
  assign out_res_day        = res_day_r;
  assign out_res_month      = res_month_r;
  assign out_res_year       = res_year_r;
  assign out_day_difference = day_difference_r;
  assign out_order          = order_r;
  assign out_range_error    = range_error_r;

endmodule

[rtl/gdda_alu.sv]
// Shared add/subtract unit with sign and zero flags used by the date sequencer.
module gdda_alu (
  input  gdda_pkg::acc_t    opa,
  input  gdda_pkg::acc_t    opb,
  input  gdda_pkg::alu_op_t op,
  output gdda_pkg::acc_t    sum,
  output logic              neg,
  output logic              zero
);
  import gdda_pkg::*;

  acc_t opb_inv;

  // One carry chain serves both directions: a - b is a + ~b + 1.
  assign opb_inv = (op == ALU_SUB) ? ~opb : opb;
  assign sum     = opa + opb_inv + acc_t'(op == ALU_SUB);
  assign neg     = sum[ACC_W-1];
  assign zero    = (sum == '0);

endmodule

[rtl/gdda_seq.sv]
// Sequencer that converts dates to day numbers and back by stepping the shared adder.
module gdda_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  gdda_pkg::req_t   req,
  output logic             busy,
  output logic             done,
  output gdda_pkg::res_t   res
);
  import gdda_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TY400,
    S_TY100,
    S_TY4,
    S_TY1,
    S_TMON,
    S_TDAY,
    S_ADDCNT,
    S_FY400,
    S_FY100,
    S_FY4,
    S_FY1,
    S_FMON,
    S_DIFF,
    S_NEG
  } state_t;

  state_t      state_r;
  req_t        req_r;
  req_t        req_c;
  logic        which_r;   // 0 while converting date A, 1 for date B
  acc_t        acc_r;
  acc_t        sa_r;
  logic [13:0] ry_r;      // years left (to day number) or year reached (from day number)
  logic [1:0]  cen_r;     // century within the 400-year cycle
  logic [4:0]  blk_r;     // four-year block within the century
  logic [1:0]  yib_r;     // year within the four-year block
  logic [3:0]  mon_r;
  logic        err_r;
  logic        done_r;
  res_t        res_r;

  logic        leap;
  acc_t        cent_len;
  acc_t        blk_len;
  acc_t        yr_len;
  acc_t        mon_len;
  logic [4:0]  cur_day;
  logic [3:0]  cur_mon;
  logic [5:0]  day_m1;

  acc_t        opa;
  acc_t        opb;
  alu_op_t     op;
  acc_t        sum;
  logic        neg;
  logic        zero;

  gdda_alu u_alu (
    .opa  (opa),
    .opb  (opb),
    .op   (op),
    .sum  (sum),
    .neg  (neg),
    .zero (zero)
  );

  // Clamp month and year once, when the transaction is taken.
  always_comb begin
    req_c = req;
    if (req.month_a == 4'd0)       req_c.month_a = 4'd1;
    else if (req.month_a > 4'd12)  req_c.month_a = 4'd12;
    if (req.month_b == 4'd0)       req_c.month_b = 4'd1;
    else if (req.month_b > 4'd12)  req_c.month_b = 4'd12;
    if (req.year_a > YEAR_MAX)     req_c.year_a  = YEAR_MAX;
    if (req.year_b > YEAR_MAX)     req_c.year_b  = YEAR_MAX;
  end

  // The position counters tell the leap status without any division.
  assign leap     = (yib_r == 2'd0) && ((blk_r != 5'd0) || (cen_r == 2'd0));
  assign cent_len = (cen_r == 2'd0) ? CENT_LEAP : CENT_PLAIN;
  assign blk_len  = ((blk_r != 5'd0) || (cen_r == 2'd0)) ? BLOCK_LEAP : BLOCK_PLAIN;
  assign yr_len   = leap ? YEAR_LEAP : YEAR_PLAIN;
  assign mon_len  = acc_t'(month_days(mon_r, leap));
  assign cur_day  = which_r ? req_r.day_b : req_r.day_a;
  assign cur_mon  = which_r ? req_r.month_b : req_r.month_a;
  assign day_m1   = {1'b0, cur_day} - 6'd1;

  always_comb begin
    opa = acc_r;
    opb = '0;
    op  = ALU_ADD;
    case (state_r)
      S_TY400:  opb = CYCLE_DAYS;
      S_TY100:  opb = cent_len;
      S_TY4:    opb = blk_len;
      S_TY1:    opb = yr_len;
      S_TMON:   opb = mon_len;
      S_TDAY:   opb = {{(ACC_W-6){day_m1[5]}}, day_m1};
      S_ADDCNT: begin
        opa = sa_r;
        opb = acc_t'(req_r.day_count[CNT_W-1:0]);
        op  = (req_r.action == ACT_SUB) ? ALU_SUB : ALU_ADD;
      end
      S_FY400: begin
        opb = CYCLE_DAYS;
        op  = ALU_SUB;
      end
      S_FY100: begin
        opb = cent_len;
        op  = ALU_SUB;
      end
      S_FY4: begin
        opb = blk_len;
        op  = ALU_SUB;
      end
      S_FY1: begin
        opb = yr_len;
        op  = ALU_SUB;
      end
      S_FMON: begin
        opb = mon_len;
        op  = ALU_SUB;
      end
      S_DIFF: begin
        opa = sa_r;
        opb = acc_r;
        op  = ALU_SUB;
      end
      S_NEG: begin
        opa = '0;
        opb = acc_r;
        op  = ALU_SUB;
      end
      default: begin
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= req_c;
            which_r <= 1'b0;
            acc_r   <= '0;
            ry_r    <= req_c.year_a;
            cen_r   <= 2'd0;
            blk_r   <= 5'd0;
            yib_r   <= 2'd0;
            state_r <= S_TY400;
          end
        end
        S_TY400: begin
          if (ry_r >= 14'd400) begin
            acc_r <= sum;
            ry_r  <= ry_r - 14'd400;
          end else begin
            state_r <= S_TY100;
          end
        end
        S_TY100: begin
          if (ry_r >= 14'd100) begin
            acc_r <= sum;
            ry_r  <= ry_r - 14'd100;
            cen_r <= cen_r + 2'd1;
          end else begin
            state_r <= S_TY4;
          end
        end
        S_TY4: begin
          if (ry_r >= 14'd4) begin
            acc_r <= sum;
            ry_r  <= ry_r - 14'd4;
            blk_r <= blk_r + 5'd1;
          end else begin
            state_r <= S_TY1;
          end
        end
        S_TY1: begin
          if (ry_r != 14'd0) begin
            acc_r <= sum;
            ry_r  <= ry_r - 14'd1;
            yib_r <= yib_r + 2'd1;
          end else begin
            mon_r   <= 4'd1;
            state_r <= S_TMON;
          end
        end
        S_TMON: begin
          if (mon_r < cur_mon) begin
            acc_r <= sum;
            mon_r <= mon_r + 4'd1;
          end else begin
            state_r <= S_TDAY;
          end
        end
        S_TDAY: begin
          if (!which_r) begin
            sa_r <= sum;
            if ((req_r.action == ACT_ADD) || (req_r.action == ACT_SUB)) begin
              state_r <= S_ADDCNT;
            end else begin
              which_r <= 1'b1;
              acc_r   <= '0;
              ry_r    <= req_r.year_b;
              cen_r   <= 2'd0;
              blk_r   <= 5'd0;
              yib_r   <= 2'd0;
              state_r <= S_TY400;
            end
          end else begin
            acc_r   <= sum;
            state_r <= S_DIFF;
          end
        end
        S_ADDCNT: begin
          ry_r  <= 14'd0;
          cen_r <= 2'd0;
          blk_r <= 5'd0;
          yib_r <= 2'd0;
          if (neg) begin
            acc_r <= '0;
            err_r <= 1'b1;
          end else if (sum > SERIAL_MAX) begin
            acc_r <= SERIAL_MAX;
            err_r <= 1'b1;
          end else begin
            acc_r <= sum;
            err_r <= 1'b0;
          end
          state_r <= S_FY400;
        end
        S_FY400: begin
          if (!neg) begin
            acc_r <= sum;
            ry_r  <= ry_r + 14'd400;
          end else begin
            state_r <= S_FY100;
          end
        end
        S_FY100: begin
          if (!neg) begin
            acc_r <= sum;
            ry_r  <= ry_r + 14'd100;
            cen_r <= cen_r + 2'd1;
          end else begin
            state_r <= S_FY4;
          end
        end
        S_FY4: begin
          if (!neg) begin
            acc_r <= sum;
            ry_r  <= ry_r + 14'd4;
            blk_r <= blk_r + 5'd1;
          end else begin
            state_r <= S_FY1;
          end
        end
        S_FY1: begin
          if (!neg) begin
            acc_r <= sum;
            ry_r  <= ry_r + 14'd1;
            yib_r <= yib_r + 2'd1;
          end else begin
            mon_r   <= 4'd1;
            state_r <= S_FMON;
          end
        end
        S_FMON: begin
          if ((mon_r < 4'd12) && !neg) begin
            acc_r <= sum;
            mon_r <= mon_r + 4'd1;
          end else begin
            // The remainder is below the month length, so day + 1 fits.
            res_r.action <= req_r.action;
            res_r.day    <= acc_r[4:0] + 5'd1;
            res_r.month  <= mon_r;
            res_r.year   <= ry_r;
            res_r.err    <= err_r;
            res_r.diff   <= '0;
            res_r.order  <= ORD_EQUAL;
            done_r       <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_DIFF: begin
          res_r.action <= req_r.action;
          res_r.day    <= '0;
          res_r.month  <= '0;
          res_r.year   <= '0;
          res_r.err    <= 1'b0;
          if (zero) begin
            res_r.order <= ORD_EQUAL;
            res_r.diff  <= '0;
            done_r      <= 1'b1;
            state_r     <= S_IDLE;
          end else if (neg) begin
            res_r.order <= ORD_A_EARLIER;
            acc_r       <= sum;
            state_r     <= S_NEG;
          end else begin
            res_r.order <= ORD_A_LATER;
            res_r.diff  <= sum[21:0];
            done_r      <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        S_NEG: begin
          res_r.diff <= sum[21:0];
          done_r     <= 1'b1;
          state_r    <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign done = done_r;
  assign res  = res_r;

endmodule
